@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the timer table.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset
`define DTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define DTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dtt_pkg.sv @@
// Package of the deadline timer table: sizes, codes, types and helpers.
// Depends on nothing; used by every module and interface of the block but dtt_ram.
`timescale 1ns / 1ps
package dtt_pkg;
	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int TIME_BITS = 48;
	localparam int WORD_BITS = 2 * TIME_BITS + 1;
	localparam logic [TIME_BITS-1:0] MARGIN_RESET = TIME_BITS'(64'd60000000);

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_CANCEL  = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_REARM   = 3'd3,
		CMD_EXPIRE  = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_INACTIVE = 2'd1,
		STAT_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_EXEC, S_SCAN, S_PICK, S_RESP, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SCAN_FRONT, SCAN_QUERY, SCAN_EXPIRE
	} scan_mode_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [SLOT_BITS-1:0] slot_out;
		logic                 fired;
		logic                 last;
		logic [TIME_BITS-1:0] wait_ms;
		logic                 none_pending;
		logic                 became_earliest;
		logic                 any_active;
	} res_t;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [SLOT_BITS-1:0] slot;
		logic [TIME_BITS-1:0] period_ms;
		logic                 repeat_req;
		logic                 start_now;
		logic [TIME_BITS-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic                 we;
		logic [SLOT_BITS-1:0] waddr;
		logic [WORD_BITS-1:0] wdata;
		logic [SLOT_BITS-1:0] raddr;
	} mem_req_t;

	// Saturating time add
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
	                                                 input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
	endfunction
endpackage

@@ rtl/core/dtt_if.sv @@
// Handshake channels of the timer table: request, result and configuration.
// Depends on dtt_pkg for field widths.
`timescale 1ns / 1ps
interface dtt_req_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    cmd;
	logic [dtt_pkg::SLOT_BITS-1:0] slot;
	logic [dtt_pkg::TIME_BITS-1:0] period_ms;
	logic                          repeat_req;
	logic                          start_now;
	logic [dtt_pkg::TIME_BITS-1:0] now_ms;
	modport source (output valid, cmd, slot, period_ms, repeat_req, start_now, now_ms,
		input ready);
	modport sink (input valid, cmd, slot, period_ms, repeat_req, start_now, now_ms,
		output ready);
endinterface

interface dtt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [dtt_pkg::SLOT_BITS-1:0] slot_out;
	logic                          fired;
	logic                          last;
	logic [dtt_pkg::TIME_BITS-1:0] wait_ms;
	logic                          none_pending;
	logic                          became_earliest;
	logic                          any_active;
	modport source (output valid, status, slot_out, fired, last, wait_ms, none_pending,
		became_earliest, any_active, input ready);
	modport sink (input valid, status, slot_out, fired, last, wait_ms, none_pending,
		became_earliest, any_active, output ready);
endinterface

interface dtt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dtt_pkg::TIME_BITS-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/dtt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module dtt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/dtt_ctrl.sv @@
// Command sequencer of the timer table: read-modify-write of slot entries and
// the one-comparator scans. Depends on dtt_pkg; drives the slot RAM.
`timescale 1ns / 1ps
module dtt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  dtt_pkg::req_t                 req,
	input  logic [dtt_pkg::TIME_BITS-1:0] margin,
	output dtt_pkg::mem_req_t             mem,
	input  logic [dtt_pkg::WORD_BITS-1:0] rdata,
	input  logic                          room,
	output logic                          res_valid,
	output dtt_pkg::res_t                 res
);
	import dtt_pkg::*;

	state_t state_q, state_nx;
	scan_mode_t mode_q;
	logic [SLOTS-1:0]     active_q, picked_q;
	logic                 front_sig_q;
	logic [TIME_BITS-1:0] last_time_q;
	// captured item
	cmd_t                 cmd_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [TIME_BITS-1:0] per_q, now_q;
	logic                 rep_q, fnow_q;
	// scan bookkeeping
	logic [SLOT_BITS:0]   c_q;
	logic                 v_s1;
	logic [SLOT_BITS-1:0] idx_s1;
	logic                 found_q, blocked_q, roll_q;
	logic [SLOT_BITS-1:0] best_q, tgt_q;
	logic [TIME_BITS-1:0] best_dl_q, tgt_dl_q, best_per_q;
	logic                 best_rep_q;
	logic [SLOT_BITS-1:0] list_q [SLOTS];
	logic [SLOT_BITS:0]   n_q;
	logic [SLOT_BITS-1:0] k_q;
	res_t                 res_q;

	logic [TIME_BITS-1:0] rd_dl, rd_per, old_start;
	logic                 rd_rep;
	logic [SLOTS-1:0]     slot_mask;
	logic                 full, any_now, unchanged, hit, elig, better, scan_end, emit_last;
	logic [SLOT_BITS-1:0] free_idx;
	logic [TIME_BITS-1:0] best_dl_fin;
	// execute-cycle setup
	res_t                 exec_res;
	logic [SLOT_BITS-1:0] exec_tgt;
	logic [TIME_BITS-1:0] exec_tgt_dl;
	scan_mode_t           exec_mode;

	assign rd_dl     = rdata[TIME_BITS-1:0];
	assign rd_per    = rdata[2*TIME_BITS-1:TIME_BITS];
	assign rd_rep    = rdata[2*TIME_BITS];
	assign old_start = (rd_dl >= rd_per) ? rd_dl - rd_per : '0;
	assign slot_mask = SLOTS'(1) << slot_q;
	assign full      = &active_q;
	assign any_now   = |active_q;
	assign unchanged = (per_q == rd_per) && !fnow_q;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = SLOT_BITS'(i);
			end
		end
	end

	// scan compare on the entry read last cycle
	assign hit = (idx_s1 != tgt_q) && active_q[idx_s1] &&
		((rd_dl < tgt_dl_q) || ((rd_dl == tgt_dl_q) && (idx_s1 < tgt_q)));
	assign elig = active_q[idx_s1] && !picked_q[idx_s1] &&
		((mode_q == SCAN_QUERY) || roll_q || (rd_dl <= now_q));
	assign better      = v_s1 && elig && (!found_q || (rd_dl < best_dl_q));
	assign scan_end    = v_s1 && (idx_s1 == SLOT_BITS'(SLOTS - 1));
	assign best_dl_fin = better ? rd_dl : best_dl_q;
	assign emit_last   = ({1'b0, k_q} == n_q - 1'b1);

	// result, scan target and scan mode decided in the execute cycle
	always_comb begin
		exec_res            = '0;
		exec_res.last       = 1'b1;
		exec_res.slot_out   = slot_q;
		exec_res.any_active = any_now;
		exec_tgt            = slot_q;
		exec_tgt_dl         = sat_add(fnow_q ? now_q : old_start, per_q);
		exec_mode           = SCAN_FRONT;
		case (cmd_q)
			CMD_ADD: begin
				exec_res.any_active = 1'b1;
				if (full) begin
					exec_res.status   = STAT_FULL;
					exec_res.slot_out = '0;
				end else begin
					exec_res.slot_out = free_idx;
					exec_tgt          = free_idx;
					exec_tgt_dl       = sat_add(now_q, per_q);
				end
			end
			CMD_CANCEL: begin
				if (!active_q[slot_q]) exec_res.status = STAT_INACTIVE;
				else exec_res.any_active = |(active_q & ~slot_mask);
			end
			CMD_REFRESH: if (!active_q[slot_q]) exec_res.status = STAT_INACTIVE;
			CMD_REARM: begin
				if (!unchanged && !active_q[slot_q]) begin
					exec_res.status = STAT_INACTIVE;
				end
				if (!unchanged && active_q[slot_q]) exec_res.any_active = 1'b1;
			end
			CMD_EXPIRE: begin
				exec_res.slot_out = '0;
				exec_mode         = SCAN_EXPIRE;
			end
			CMD_QUERY: begin
				exec_res.slot_out = '0;
				exec_mode         = SCAN_QUERY;
			end
			default: exec_res.slot_out = '0;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_nx = S_RD;
			S_RD:   state_nx = S_EXEC;
			S_EXEC: begin
				case (cmd_q)
					CMD_ADD:    state_nx = full ? S_RESP : S_SCAN;
					CMD_REARM:  state_nx = (unchanged || !active_q[slot_q]) ? S_RESP : S_SCAN;
					CMD_EXPIRE: state_nx = any_now ? S_SCAN : S_RESP;
					CMD_QUERY:  state_nx = S_SCAN;
					default:    state_nx = S_RESP;
				endcase
			end
			S_SCAN: begin
				if (scan_end) begin
					if (mode_q != SCAN_EXPIRE) state_nx = S_RESP;
					else if (found_q || better) state_nx = S_PICK;
					else if (n_q == '0) state_nx = S_RESP;
					else state_nx = S_EMIT;
				end
			end
			S_PICK: state_nx = S_SCAN;
			S_RESP: if (room) state_nx = S_IDLE;
			S_EMIT: if (room && emit_last) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs: handshake, RAM port, result
	always_comb begin
		req_ready = (state_q == S_IDLE);
		mem.raddr = (state_q == S_SCAN) ? c_q[SLOT_BITS-1:0] : slot_q;
		mem.we    = 1'b0;
		mem.waddr = slot_q;
		mem.wdata = {rd_rep, rd_per, sat_add(now_q, rd_per)};
		if (state_q == S_EXEC) begin
			case (cmd_q)
				CMD_ADD: begin
					mem.we    = !full;
					mem.waddr = free_idx;
					mem.wdata = {rep_q, per_q, sat_add(now_q, per_q)};
				end
				CMD_REFRESH: mem.we = active_q[slot_q];
				CMD_REARM: begin
					mem.we    = !unchanged && active_q[slot_q];
					mem.wdata = {rd_rep, per_q,
						sat_add(fnow_q ? now_q : old_start, per_q)};
				end
				default: mem.we = 1'b0;
			endcase
		end else if (state_q == S_PICK) begin
			mem.we    = best_rep_q;
			mem.waddr = best_q;
			mem.wdata = {best_rep_q, best_per_q, sat_add(now_q, best_per_q)};
		end
		res_valid = room && ((state_q == S_RESP) || (state_q == S_EMIT));
		res       = res_q;
		if (state_q == S_EMIT) begin
			res            = '0;
			res.status     = STAT_OK;
			res.slot_out   = list_q[k_q];
			res.fired      = 1'b1;
			res.last       = emit_last;
			res.any_active = any_now;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			front_sig_q <= 1'b0;
			last_time_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= (state_q == S_SCAN) && (c_q < (SLOT_BITS+1)'(SLOTS));
			if (state_q == S_EXEC) begin
				case (cmd_q)
					CMD_ADD:    if (!full) active_q[free_idx] <= 1'b1;
					CMD_CANCEL: active_q <= active_q & ~slot_mask;
					CMD_EXPIRE: if (any_now) last_time_q <= now_q;
					CMD_QUERY:  front_sig_q <= 1'b0;
					default:    ;
				endcase
			end
			if (state_q == S_PICK && !best_rep_q) begin
				active_q[best_q] <= 1'b0;
			end
			if (state_q == S_SCAN && scan_end && mode_q == SCAN_FRONT &&
				!(blocked_q || hit) && !front_sig_q) begin
				front_sig_q <= 1'b1;
			end
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			cmd_q  <= cmd_t'(req.cmd);
			slot_q <= req.slot;
			per_q  <= req.period_ms;
			rep_q  <= req.repeat_req;
			fnow_q <= req.start_now;
			now_q  <= req.now_ms;
		end
		if (state_q == S_EXEC || state_q == S_PICK) begin
			c_q       <= '0;
			found_q   <= 1'b0;
			blocked_q <= 1'b0;
		end
		if (state_q == S_EXEC) begin
			res_q    <= exec_res;
			picked_q <= '0;
			n_q      <= '0;
			k_q      <= '0;
			tgt_q    <= exec_tgt;
			tgt_dl_q <= exec_tgt_dl;
			mode_q   <= exec_mode;
			roll_q   <= (last_time_q > margin) && (now_q < last_time_q - margin);
		end
		// one entry a cycle through the read port
		if (state_q == S_SCAN) begin
			if (c_q < (SLOT_BITS+1)'(SLOTS)) c_q <= c_q + 1'b1;
			idx_s1 <= c_q[SLOT_BITS-1:0];
			if (v_s1 && hit) blocked_q <= 1'b1;
			if (better) begin
				found_q    <= 1'b1;
				best_q     <= idx_s1;
				best_dl_q  <= rd_dl;
				best_per_q <= rd_per;
				best_rep_q <= rd_rep;
			end
			if (scan_end) begin
				case (mode_q)
					SCAN_FRONT: res_q.became_earliest <= !(blocked_q || hit) && !front_sig_q;
					SCAN_QUERY: begin
						res_q.none_pending <= !(found_q || better);
						res_q.any_active   <= found_q || better;
						res_q.wait_ms      <= !(found_q || better) ? '1 :
							(now_q >= best_dl_fin) ? '0 : best_dl_fin - now_q;
					end
					default: res_q.any_active <= 1'b1;
				endcase
			end
		end
		// record the pick
		if (state_q == S_PICK) begin
			picked_q[best_q]          <= 1'b1;
			list_q[n_q[SLOT_BITS-1:0]] <= best_q;
			n_q                       <= n_q + 1'b1;
		end
		if (state_q == S_EMIT && room) begin
			k_q <= k_q + 1'b1;
		end
	end
endmodule

@@ rtl/core/deadline_timer_table_core.sv @@
// Top level of the deadline timer table: channels, margin register, result
// register. Depends on dtt_pkg, dtt_if, dtt_ram and dtt_ctrl.
`timescale 1ns / 1ps
// Timer table of SLOTS slots whose deadline, period and repeat flag live in
// one synchronous RAM with a single read port. Every command first reads
// the entry named by its slot field. Add (unless the table is full) and
// rearm (when it changes an active slot) then scan all slots, one entry a
// cycle, to see whether the slot became the earliest. The query scans once
// for the minimum. The expiry check, when any slot is active, scans once per
// due slot plus once more to find none left; cancel, refresh and unknown
// commands do not scan. A result stall holds the command in its response or
// emit state. A result waits in an output register; the next item is taken
// once the command's results have all entered it. The margin register may
// be written at any time the table is idle.
module deadline_timer_table_core (
	input logic   clk,
	input logic   arst_n,
	dtt_cfg_if.sink cfg,
	dtt_req_if.sink req,
	dtt_rsp_if.source rsp
);
	import dtt_pkg::*;

	logic [TIME_BITS-1:0] margin_q;
	res_t                 rsp_q, res;
	logic                 rsp_v_q, res_valid, room;
	req_t                 req_pl;
	mem_req_t             mem;
	logic [WORD_BITS-1:0] rdata;

	// rollback margin register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg.valid) begin
			margin_q <= cfg.data;
		end
	end

	assign req_pl = '{cmd: req.cmd, slot: req.slot, period_ms: req.period_ms,
		repeat_req: req.repeat_req, start_now: req.start_now, now_ms: req.now_ms};

	dtt_ram #(.DEPTH(SLOTS), .WIDTH(WORD_BITS)) u_ram (
		.clk  (clk),
		.we   (mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wdata),
		.raddr(mem.raddr),
		.rdata(rdata)
	);

	dtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req      (req_pl),
		.margin   (margin_q),
		.mem      (mem),
		.rdata    (rdata),
		.room     (room),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register
	assign room = !rsp_v_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (room) begin
			rsp_v_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (room && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid           = rsp_v_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.slot_out        = rsp_q.slot_out;
	assign rsp.fired           = rsp_q.fired;
	assign rsp.last            = rsp_q.last;
	assign rsp.wait_ms         = rsp_q.wait_ms;
	assign rsp.none_pending    = rsp_q.none_pending;
	assign rsp.became_earliest = rsp_q.became_earliest;
	assign rsp.any_active      = rsp_q.any_active;
endmodule

@@ rtl/core/dtt_checker.sv @@
// Port-level checks of the timer table and their binding to the top level.
// Depends on assert_macros.svh and dtt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [1:0]                    status,
	input logic                          fired,
	input logic [dtt_pkg::TIME_BITS-1:0] wait_ms,
	input logic                          none_pending,
	input logic                          became_earliest,
	input logic                          any_active
);
	import dtt_pkg::*;

	`DTT_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`DTT_ASSERT(a_fired_ok, clk, arst_n, !(rsp_valid && fired) || status == STAT_OK, "fired item with error status")
	`DTT_ASSERT(a_none, clk, arst_n, !(rsp_valid && none_pending) || (wait_ms == '1 && !any_active), "empty query inconsistent")
	`DTT_ASSERT(a_early, clk, arst_n, !(rsp_valid && became_earliest) || (any_active && !fired), "earliest mark without active slot")
endmodule

bind deadline_timer_table_core dtt_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.fired          (rsp.fired),
	.wait_ms        (rsp.wait_ms),
	.none_pending   (rsp.none_pending),
	.became_earliest(rsp.became_earliest),
	.any_active     (rsp.any_active)
);
